>>> rtl/dpwfb_pkg.sv
// ----------------------------------------------------------------------------
// Datapoint write frame package
// Constants, request type and frame position limits for the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dpwfb_pkg;

    localparam logic [7:0] HDR_SYNC_0   = 8'h55;
    localparam logic [7:0] HDR_SYNC_1   = 8'hAA;
    localparam logic [7:0] HDR_CMD      = 8'h06;
    localparam logic [7:0] TYPE_WIDE    = 8'h02;
    localparam logic [7:0] SIZE_WIDE    = 8'h04;
    localparam logic [7:0] SIZE_NARROW  = 8'h01;
    localparam logic [7:0] LEN_WIDE     = 8'h08;
    localparam logic [7:0] LEN_NARROW   = 8'h05;

    // Frame positions: checksum sits at 16 for wide frames, 13 otherwise.
    localparam int unsigned IDX_W = 5;
    localparam logic [IDX_W-1:0] LAST_WIDE   = 5'd16;
    localparam logic [IDX_W-1:0] LAST_NARROW = 5'd13;

    typedef struct packed {
        logic [7:0]  point_id;
        logic [7:0]  point_type;
        logic [31:0] point_value;
    } t_req;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_sel;

endpackage

`default_nettype wire

>>> rtl/dpwfb_byte_mux.sv
// ----------------------------------------------------------------------------
// Frame byte selector
// Picks the frame byte for a given position of the request's frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dpwfb_byte_mux
    import dpwfb_pkg::*;
(
    input  wire t_req             i_req,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [7:0]       i_sum,
    output t_sel                  o_sel
);

    logic w_wide;

    assign w_wide = (i_req.point_type == TYPE_WIDE);

    always_comb begin
        o_sel.frame_byte = 8'h00;
        o_sel.frame_end  = 1'b0;
        case (i_idx)
            5'd0:  o_sel.frame_byte = HDR_SYNC_0;
            5'd1:  o_sel.frame_byte = HDR_SYNC_1;
            5'd4:  o_sel.frame_byte = HDR_CMD;
            5'd7:  o_sel.frame_byte = w_wide ? LEN_WIDE : LEN_NARROW;
            5'd8:  o_sel.frame_byte = i_req.point_id;
            5'd9:  o_sel.frame_byte = i_req.point_type;
            5'd11: o_sel.frame_byte = w_wide ? SIZE_WIDE : SIZE_NARROW;
            5'd12: o_sel.frame_byte = w_wide ? i_req.point_value[31:24]
                                             : i_req.point_value[7:0];
            5'd13: begin
                if (w_wide) begin
                    o_sel.frame_byte = i_req.point_value[23:16];
                end else begin
                    o_sel.frame_byte = i_sum;
                    o_sel.frame_end  = 1'b1;
                end
            end
            5'd14: o_sel.frame_byte = i_req.point_value[15:8];
            5'd15: o_sel.frame_byte = i_req.point_value[7:0];
            5'd16: begin
                o_sel.frame_byte = i_sum;
                o_sel.frame_end  = 1'b1;
            end
            default: o_sel.frame_byte = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/datapoint_write_frame_builder.sv
// ----------------------------------------------------------------------------
// Datapoint write frame builder
// Turns one write request into a serial frame with a trailing checksum word.
// ----------------------------------------------------------------------------
// The request is registered first; each frame word is then registered at the output.
// Throughput: one word per cycle while the receiver does not stall; a type-2
// request gives a 17-word frame and any other request a 14-word frame.
// The next request is taken as the last word of a frame is loaded.
// Reset clears the busy flag, the position counter, the running sum and the
// output valid.
`default_nettype none

module datapoint_write_frame_builder
    import dpwfb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_point_id,
    input  wire logic [7:0]  i_point_type,
    input  wire logic [31:0] i_point_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_frame_byte,
    output logic             o_frame_end
);

    t_req             r_req;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_sum;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;

    t_sel             w_sel;
    logic             w_advance;
    logic             w_load;
    logic             w_last;
    logic             w_accept;

    dpwfb_byte_mux u_byte_mux (
        .i_req (r_req),
        .i_idx (r_idx),
        .i_sum (r_sum),
        .o_sel (w_sel)
    );

    assign w_advance = !r_out_valid || i_ready;
    assign w_load    = r_busy && w_advance;
    assign w_last    = w_sel.frame_end;
    assign o_ready   = !r_busy || (w_load && w_last);
    assign w_accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_sum       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                if (w_last) begin
                    r_idx <= '0;
                    r_sum <= 8'h00;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    r_sum <= r_sum + w_sel.frame_byte;
                end
            end
            if (w_advance) begin
                r_out_valid <= w_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.point_id    <= i_point_id;
            r_req.point_type  <= i_point_type;
            r_req.point_value <= i_point_value;
        end
        if (w_load) begin
            r_out_byte <= w_sel.frame_byte;
            r_out_end  <= w_sel.frame_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

    // The position counter never runs past the checksum of a wide frame.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_WIDE)
        else $error("frame position beyond checksum");

    // Loading the checksum word returns the counter and sum to the frame start.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_idx == '0 && r_sum == 8'h00))
        else $error("frame position did not wrap after checksum");

    // A taken request always leaves the builder busy with its frame.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_idx == '0))
        else $error("request taken but frame not started");

endmodule

`default_nettype wire
